FILE: rtl/tdp_pkg.sv
// tdp_pkg: shared constants, types and codes for the tensor dimension permute core.
// No dependencies; imported by every module of the block except the generic RAM.
package tdp_pkg;

	localparam int MAX_DIMS   = 4;
	localparam int MAX_ELEMS  = 4096;
	localparam int DATA_WIDTH = 64;

	localparam int ADDR_W     = $clog2(MAX_ELEMS);
	localparam int CNT_W      = $clog2(MAX_ELEMS + 2);
	localparam int LEN_W      = 13;
	localparam int ND_W       = 3;
	localparam int PERM_W     = $clog2(MAX_DIMS);
	localparam int PERM_REG_W = 8;
	localparam int SUM_W      = CNT_W + $clog2(MAX_DIMS);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int STATUS_W   = 3;
	localparam int SETTLE     = 6;
	localparam int SETTLE_W   = $clog2(SETTLE + 1);

	localparam logic [PERM_REG_W-1:0] PERM_RESET = 8'hE4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEN_0    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEN_1    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEN_2    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEN_3    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PERM     = 3'd5;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_MISMATCH = 3'd1,
		ST_IDENTITY = 3'd2,
		ST_INVALID  = 3'd3,
		ST_NODATA   = 3'd4
	} status_t;

	typedef logic [LEN_W-1:0] len_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// geometry of one load, derived from the configuration registers
	typedef struct packed {
		logic [ND_W-1:0]          nd;
		len_t [MAX_DIMS-1:0]      len;
		cnt_t [MAX_DIMS-1:0]      stride;
		cnt_t                     total;
		logic                     invalid;
		logic                     identity;
	} geom_t;

endpackage

FILE: rtl/tensor_dimension_permute_core.sv
// Path from an accepted read or last load beat to its result beat: input register, then
// result register fed by the buffer read. Throughput: one beat per cycle while m_tready allows.
// s_tready drops after each configuration write while strides settle.
// Reset clears control state, restores register defaults and reports no data;
// buffer contents are undefined until loaded.
module tensor_dimension_permute_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tdp_pkg::DATA_WIDTH-1:0]    s_tdata,   // element_value
	input  logic                              s_tuser,   // opcode
	input  logic                              s_tlast,   // last_element
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tdp_pkg::DATA_WIDTH-1:0]    m_tdata,   // out_value
	output logic [tdp_pkg::STATUS_W-1:0]      m_tuser,   // status
	output logic                              m_tlast,   // last_out
	input  logic                              cfg_we,
	input  logic [tdp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tdp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tdp_pkg::*;

	geom_t                 cfg_g;
	logic                  settled;

	logic                  valid_s1;
	logic                  op_s1;
	logic [DATA_WIDTH-1:0] data_s1;
	logic                  last_s1;

	logic                  valid_s2;
	status_t               status_s2;
	logic                  last_s2;
	logic                  sel_s2;

	logic                  active_q;
	status_t               load_status_q;
	cnt_t                  cnt_q;
	logic [ADDR_W-1:0]     rp_q;
	geom_t                 lat_q;

	logic                  adv;
	logic                  fire;
	logic                  fresh;
	logic                  is_load;
	logic                  is_read;
	geom_t                 cur_g;
	cnt_t                  cnt_cur;
	cnt_t                  cnt_next;
	status_t               fin_status;
	logic                  rd_ok;
	logic                  rd_last;
	logic [SUM_W-1:0]      addr;
	logic                  ram_we;
	logic [DATA_WIDTH-1:0] ram_rdata;

	tdp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (cfg_g),
		.settled   (settled)
	);

	assign adv      = !valid_s2 || m_tready;
	assign fire     = valid_s1 && adv;
	assign s_tready = settled && (!valid_s1 || adv);

	always_comb begin
		fresh    = !active_q;
		cur_g    = active_q ? lat_q : cfg_g;
		is_load  = fire && (op_s1 == OP_LOAD);
		is_read  = fire && (op_s1 == OP_READ);
		cnt_cur  = fresh ? '0 : cnt_q;
		cnt_next = (cnt_cur <= CNT_W'(MAX_ELEMS)) ? cnt_cur + CNT_W'(1) : cnt_cur;
		priority if (cur_g.invalid) begin
			fin_status = ST_INVALID;
		end else if (cur_g.total > CNT_W'(MAX_ELEMS) || cnt_next != cur_g.total) begin
			fin_status = ST_MISMATCH;
		end else if (cur_g.identity) begin
			fin_status = ST_IDENTITY;
		end else begin
			fin_status = ST_OK;
		end
		rd_ok   = !active_q && (load_status_q == ST_OK || load_status_q == ST_IDENTITY);
		rd_last = (CNT_W'(rp_q) + CNT_W'(1)) >= lat_q.total;
		ram_we  = is_load && (addr < SUM_W'(MAX_ELEMS));
	end

	tdp_addr_gen u_addr_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (is_load),
		.fresh  (fresh),
		.geom   (cur_g),
		.addr   (addr)
	);

	tdp_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_ELEMS)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr[ADDR_W-1:0]),
		.wdata (data_s1),
		.re    (is_read && rd_ok),
		.raddr (rp_q),
		.rdata (ram_rdata)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// load and read bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			load_status_q <= ST_NODATA;
			cnt_q         <= '0;
			rp_q          <= '0;
		end else if (is_load) begin
			cnt_q <= cnt_next;
			if (last_s1) begin
				load_status_q <= fin_status;
				rp_q          <= '0;
				active_q      <= 1'b0;
			end else begin
				active_q <= 1'b1;
				if (fresh) load_status_q <= ST_NODATA;
			end
		end else if (is_read && rd_ok) begin
			rp_q <= rd_last ? '0 : rp_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (is_load && fresh) begin
			lat_q <= cfg_g;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= fire && (op_s1 == OP_READ || last_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (op_s1 == OP_LOAD) begin
				status_s2 <= fin_status;
			end else begin
				status_s2 <= active_q ? ST_NODATA : load_status_q;
			end
			last_s2 <= is_read && rd_ok && rd_last;
			sel_s2  <= is_read && rd_ok;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = sel_s2 ? ram_rdata : '0;
	assign m_tuser  = status_s2;
	assign m_tlast  = last_s2;

endmodule

FILE: rtl/tdp_ram.sv
// tdp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/tdp_cfg.sv
// tdp_cfg: configuration registers and the pipelined derivation of strides, total and checks.
// Depends on tdp_pkg.
module tdp_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tdp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tdp_pkg::CFG_DATA_W-1:0]    cfg_data,
	output tdp_pkg::geom_t                    geom,
	output logic                              settled
);
	import tdp_pkg::*;

	localparam cnt_t SAT = CNT_W'(MAX_ELEMS + 1);

	function automatic cnt_t sat_mul(input cnt_t a, input len_t b);
		logic [CNT_W+LEN_W-1:0] prod;
		prod = (CNT_W+LEN_W)'(a) * (CNT_W+LEN_W)'(b);
		return (prod > (CNT_W+LEN_W)'(SAT)) ? SAT : prod[CNT_W-1:0];
	endfunction

	logic [ND_W-1:0]       nd_raw_q;
	len_t [MAX_DIMS-1:0]   len_q;
	logic [PERM_REG_W-1:0] perm_q;
	logic [SETTLE_W-1:0]   settle_q;

	// derived stages
	logic [ND_W-1:0]       nd_q;
	len_t [MAX_DIMS-1:0]   leneff_q;
	logic                  invalid_q;
	logic                  identity_q;
	cnt_t [MAX_DIMS-1:0]   prod_q;
	cnt_t [MAX_DIMS-1:0]   stride_q;

	logic [ND_W-1:0]       nd_c;
	len_t [MAX_DIMS-1:0]   leneff_c;
	logic                  invalid_c;
	logic                  identity_c;
	logic [PERM_W-1:0]     fld;
	cnt_t [MAX_DIMS:0]     pp;
	cnt_t [MAX_DIMS-1:0]   stride_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_raw_q <= ND_W'(1);
			len_q    <= {MAX_DIMS{LEN_W'(1)}};
			perm_q   <= PERM_RESET;
			settle_q <= SETTLE_W'(SETTLE);
		end else begin
			if (cfg_we) begin
				settle_q <= SETTLE_W'(SETTLE);
				unique case (cfg_index)
					REG_NUM_DIMS: nd_raw_q <= cfg_data[ND_W-1:0];
					REG_LEN_0:    len_q[0] <= cfg_data[LEN_W-1:0];
					REG_LEN_1:    len_q[1] <= cfg_data[LEN_W-1:0];
					REG_LEN_2:    len_q[2] <= cfg_data[LEN_W-1:0];
					REG_LEN_3:    len_q[3] <= cfg_data[LEN_W-1:0];
					REG_PERM:     perm_q   <= cfg_data[PERM_REG_W-1:0];
					default: ;
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - SETTLE_W'(1);
			end
		end
	end

	always_comb begin
		if (nd_raw_q == '0) begin
			nd_c = ND_W'(1);
		end else if (nd_raw_q > ND_W'(MAX_DIMS)) begin
			nd_c = ND_W'(MAX_DIMS);
		end else begin
			nd_c = nd_raw_q;
		end
		invalid_c  = 1'b0;
		identity_c = 1'b1;
		leneff_c   = '0;
		fld        = '0;
		for (int p = 0; p < MAX_DIMS; p++) begin
			fld = perm_q[PERM_W*p +: PERM_W];
			leneff_c[p] = LEN_W'(1);
			if (ND_W'(p) < nd_c) begin
				leneff_c[p] = len_q[fld];
				if (ND_W'(fld) >= nd_c) invalid_c = 1'b1;
				if (fld != PERM_W'(p)) identity_c = 1'b0;
				for (int q = 0; q < p; q++) begin
					if (perm_q[PERM_W*q +: PERM_W] == fld) invalid_c = 1'b1;
				end
			end
		end
	end

	// stride of a source dimension: product of the lengths placed after it
	always_comb begin
		pp           = '0;
		pp[MAX_DIMS] = CNT_W'(1);
		for (int p = 0; p < MAX_DIMS; p++) begin
			pp[p] = prod_q[p];
		end
		stride_c = '0;
		for (int s = 0; s < MAX_DIMS; s++) begin
			for (int p = MAX_DIMS - 1; p >= 0; p--) begin
				if (ND_W'(p) < nd_q && perm_q[PERM_W*p +: PERM_W] == PERM_W'(s)) begin
					stride_c[s] = pp[p+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		nd_q       <= nd_c;
		leneff_q   <= leneff_c;
		invalid_q  <= invalid_c;
		identity_q <= identity_c;
		prod_q[MAX_DIMS-1] <= sat_mul(CNT_W'(1), leneff_q[MAX_DIMS-1]);
		for (int p = 0; p < MAX_DIMS - 1; p++) begin
			prod_q[p] <= sat_mul(prod_q[p+1], leneff_q[p]);
		end
		stride_q   <= stride_c;
	end

	assign settled = (settle_q == '0);

	always_comb begin
		geom.nd       = nd_q;
		geom.len      = len_q;
		geom.stride   = stride_q;
		geom.total    = prod_q[0];
		geom.invalid  = invalid_q;
		geom.identity = identity_q;
	end

endmodule

FILE: rtl/tdp_addr_gen.sv
// tdp_addr_gen: mixed-radix source index counter with per-dimension stride terms.
// Depends on tdp_pkg.
module tdp_addr_gen (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   fresh,
	input  tdp_pkg::geom_t         geom,
	output logic [tdp_pkg::SUM_W-1:0] addr
);
	import tdp_pkg::*;

	len_t [MAX_DIMS-1:0] idx_q;
	cnt_t [MAX_DIMS-1:0] term_q;

	len_t [MAX_DIMS-1:0] idx_cur;
	cnt_t [MAX_DIMS-1:0] term_cur;
	logic [MAX_DIMS-1:0] wrap;
	logic [MAX_DIMS-1:0] inc;
	logic                carry;
	len_t [MAX_DIMS-1:0] idx_nxt;
	cnt_t [MAX_DIMS-1:0] term_nxt;

	always_comb begin
		idx_cur  = fresh ? '0 : idx_q;
		term_cur = fresh ? '0 : term_q;
		addr     = '0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			addr = addr + SUM_W'(term_cur[d]);
			wrap[d] = ({1'b0, idx_cur[d]} + (LEN_W+1)'(1)) >= {1'b0, geom.len[d]};
		end
		// innermost dimension in use always counts; carries ripple outwards
		carry = 1'b1;
		inc   = '0;
		for (int d = MAX_DIMS - 1; d >= 0; d--) begin
			if (ND_W'(d) < geom.nd) begin
				inc[d] = carry;
				carry  = carry & wrap[d];
			end
		end
		idx_nxt  = idx_cur;
		term_nxt = term_cur;
		for (int d = 0; d < MAX_DIMS; d++) begin
			if (inc[d]) begin
				if (wrap[d]) begin
					idx_nxt[d]  = '0;
					term_nxt[d] = '0;
				end else begin
					idx_nxt[d]  = idx_cur[d] + LEN_W'(1);
					term_nxt[d] = term_cur[d] + geom.stride[d];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			term_q <= '0;
		end else if (step) begin
			idx_q  <= idx_nxt;
			term_q <= term_nxt;
		end
	end

endmodule

FILE: test/tensor_dimension_permute_core_tb.sv
// Testbench for tensor_dimension_permute_core: loads row-major arrays of up to four
// dimensions, drains them in permuted order and checks every result beat against a predictor.
// Depends on tdp_pkg and the core RTL only; stimulus is directed first, then random.
module tensor_dimension_permute_core_tb;
	import tdp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
	localparam logic [7:0] ALL_REGS = 8'((1 << REG_NUM_DIMS) | (1 << REG_LEN_0) |
		(1 << REG_LEN_1) | (1 << REG_LEN_2) | (1 << REG_LEN_3) | (1 << REG_PERM));
	localparam int DRAIN_CYCLES = 6;
	localparam int RANDOM_BEATS = 500;
	localparam int SMALL_ARRAY  = 96;
	localparam int CUBE_SIZE    = 64;

	typedef struct {
		logic [DATA_WIDTH-1:0] value;
		status_t               status;
		logic                  last;
	} permuted_beat_t;

	class permute_scoreboard;
		int unsigned           reg_nd;
		int unsigned           reg_len[MAX_DIMS];
		int unsigned           reg_perm;
		int                    geo_nd;
		longint                geo_len[MAX_DIMS];
		int                    geo_perm[MAX_DIMS];
		longint                geo_stride[MAX_DIMS];
		longint                geo_total;
		logic [DATA_WIDTH-1:0] elem_store[MAX_ELEMS];
		longint                src_idx[MAX_DIMS];
		longint                load_cnt;
		longint                rd_ptr;
		status_t               load_st;
		bit                    loading;
		permuted_beat_t        pending[$];
		int                    errors;
		int                    beats_in;
		int                    beats_out;
		int                    load_hist[1 << STATUS_W];

		function new();
			reg_nd = 1;
			foreach (reg_len[d]) reg_len[d] = 1;
			reg_perm = PERM_RESET;
			foreach (src_idx[d]) src_idx[d] = 0;
			foreach (load_hist[i]) load_hist[i] = 0;
			load_cnt = 0;
			rd_ptr = 0;
			load_st = ST_NODATA;
			loading = 0;
			geo_total = 0;
			errors = 0;
			beats_in = 0;
			beats_out = 0;
			latch_geometry();
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_NUM_DIMS: reg_nd = data[ND_W-1:0];
				REG_LEN_0:    reg_len[0] = data;
				REG_LEN_1:    reg_len[1] = data;
				REG_LEN_2:    reg_len[2] = data;
				REG_LEN_3:    reg_len[3] = data;
				REG_PERM:     reg_perm = data[PERM_REG_W-1:0];
				default: ;
			endcase
		endfunction

		function int eff_dims();
			int nd;
			nd = reg_nd;
			if (nd == 0)
				nd = 1;
			if (nd > MAX_DIMS)
				nd = MAX_DIMS;
			return nd;
		endfunction

		function longint planned_size();
			longint prod = 1;
			int nd;
			nd = eff_dims();
			for (int d = 0; d < nd; d++) begin
				prod *= reg_len[d];
				if (prod > MAX_ELEMS + 1)
					prod = MAX_ELEMS + 1;
			end
			return prod;
		endfunction

		function void latch_geometry();
			longint acc = 1;
			int s;
			geo_nd = eff_dims();
			for (int d = 0; d < MAX_DIMS; d++) begin
				geo_len[d] = reg_len[d];
				geo_perm[d] = (reg_perm >> (2 * d)) & 3;
				geo_stride[d] = 0;
			end
			for (int d = geo_nd; d > 0; d--) begin
				s = geo_perm[d-1];
				if (s < geo_nd) begin
					geo_stride[s] = acc;
					acc *= geo_len[s];
				end
			end
		endfunction

		// invalid order beats size checks, size beats identity
		function status_t close_load();
			bit ident = 1;
			longint prod = 1;
			for (int p = 0; p < geo_nd; p++) begin
				if (geo_perm[p] >= geo_nd)
					return ST_INVALID;
				for (int q = 0; q < p; q++)
					if (geo_perm[q] == geo_perm[p])
						return ST_INVALID;
				if (geo_perm[p] != p)
					ident = 0;
			end
			for (int p = 0; p < geo_nd; p++) begin
				prod *= geo_len[p];
				if (prod > MAX_ELEMS + 1)
					prod = MAX_ELEMS + 1;
			end
			geo_total = prod;
			if (prod > MAX_ELEMS || load_cnt != prod)
				return ST_MISMATCH;
			return ident ? ST_IDENTITY : ST_OK;
		endfunction

		function void take_input(logic op, logic [DATA_WIDTH-1:0] value, logic last);
			permuted_beat_t r;
			longint addr;
			int d;
			beats_in++;
			r.value = '0;
			r.status = ST_OK;
			r.last = 1'b0;
			if (op == OP_LOAD) begin
				if (!loading) begin
					latch_geometry();
					foreach (src_idx[i]) src_idx[i] = 0;
					load_cnt = 0;
					load_st = ST_NODATA;
					loading = 1;
				end
				addr = 0;
				for (int i = 0; i < geo_nd; i++)
					addr += src_idx[i] * geo_stride[i];
				if (addr < MAX_ELEMS)
					elem_store[addr] = value;
				if (load_cnt <= MAX_ELEMS)
					load_cnt++;
				d = geo_nd - 1;
				src_idx[d]++;
				while (src_idx[d] >= geo_len[d]) begin
					src_idx[d] = 0;
					if (d == 0)
						break;
					d--;
					src_idx[d]++;
				end
				if (!last)
					return;
				load_st = close_load();
				rd_ptr = 0;
				loading = 0;
				load_hist[load_st]++;
				r.status = load_st;
			end else if (loading || (load_st != ST_OK && load_st != ST_IDENTITY)) begin
				r.status = loading ? ST_NODATA : load_st;
			end else begin
				if (rd_ptr < MAX_ELEMS)
					r.value = elem_store[rd_ptr];
				r.status = load_st;
				if (rd_ptr + 1 >= geo_total) begin
					r.last = 1'b1;
					rd_ptr = 0;
				end else begin
					rd_ptr++;
				end
			end
			pending.push_back(r);
		endfunction

		function void check_output(logic [DATA_WIDTH-1:0] v, logic [STATUS_W-1:0] st, logic lst);
			permuted_beat_t e;
			beats_out++;
			if (pending.size() == 0) begin
				$error("unexpected result beat: value %h status %0d last %0b", v, st, lst);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (v !== e.value) begin
				$error("out_value: expected %h, got %h", e.value, v);
				errors++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				errors++;
			end
			if (lst !== e.last) begin
				$error("last_out: expected %0b, got %0b", e.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [DATA_WIDTH-1:0] s_tdata;   // element_value
	logic                  s_tuser;   // opcode
	logic                  s_tlast;   // last_element
	logic                  m_tvalid;
	logic                  m_tready;
	logic [DATA_WIDTH-1:0] m_tdata;   // out_value
	logic [STATUS_W-1:0]   m_tuser;   // status
	logic                  m_tlast;   // last_out
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	permute_scoreboard chk = new();

	logic [CFG_DATA_W-1:0] reg_plan[8];
	bit                    tx_gappy;
	bit                    rx_gappy;
	int                    stall_left;
	int                    random_beats;
	bit                    big_done;

	tensor_dimension_permute_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tensor_dimension_permute_core_tb: FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [DATA_WIDTH-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// result side: check accepted beats, then stall at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			chk.check_output(m_tdata, m_tuser, m_tlast);
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if (rx_gappy && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	task automatic send_beat(input logic op, input logic [DATA_WIDTH-1:0] value, input logic last);
		int gap;
		gap = tx_gappy ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= value;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		chk.take_input(op, value, last);
	endtask

	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		while (chk.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_registers(input logic [7:0] mask);
		bit any;
		any = 0;
		for (int i = 0; i < 8; i++) begin
			if (mask[i]) begin
				cfg_we    <= 1'b1;
				cfg_index <= i[CFG_IDX_W-1:0];
				cfg_data  <= reg_plan[i];
				@(posedge clk);
				chk.note_config(i[CFG_IDX_W-1:0], reg_plan[i]);
				any = 1;
			end
		end
		if (any)
			cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(input int nd, input int l0, input int l1, input int l2,
			input int l3, input logic [PERM_REG_W-1:0] perm, input logic [7:0] mask);
		logic [31:0] noise;
		pause_until_drained();
		noise = $urandom;
		reg_plan[REG_NUM_DIMS] = {noise[CFG_DATA_W-1:ND_W], nd[ND_W-1:0]};
		reg_plan[REG_LEN_0]    = l0[CFG_DATA_W-1:0];
		reg_plan[REG_LEN_1]    = l1[CFG_DATA_W-1:0];
		reg_plan[REG_LEN_2]    = l2[CFG_DATA_W-1:0];
		reg_plan[REG_LEN_3]    = l3[CFG_DATA_W-1:0];
		noise = $urandom;
		reg_plan[REG_PERM]     = {noise[CFG_DATA_W-1:PERM_REG_W], perm};
		noise = $urandom;
		reg_plan[REG_SPARE_A]  = noise[CFG_DATA_W-1:0];
		reg_plan[REG_SPARE_B]  = noise[2*CFG_DATA_W-1:CFG_DATA_W];
		program_registers(mask);
	endtask

	task automatic load_run(input int n, input int mid_read);
		for (int i = 0; i < n; i++) begin
			if (i == mid_read)
				send_beat(OP_READ, rand_word(), 1'($urandom_range(0, 1)));
			send_beat(OP_LOAD, rand_word(), i == n - 1);
		end
	endtask

	task automatic read_run(input int n);
		for (int i = 0; i < n; i++)
			send_beat(OP_READ, rand_word(), 1'($urandom_range(0, 1)));
	endtask

	task automatic plan_random_config();
		int nd;
		int eff;
		int r;
		int t;
		int lens[MAX_DIMS];
		int order[MAX_DIMS];
		logic [31:0] noise;
		logic [PERM_REG_W-1:0] perm;
		logic [7:0] mask;
		r = $urandom_range(0, 99);
		nd = (r < 90) ? $urandom_range(1, MAX_DIMS) :
			(r < 95) ? 0 : $urandom_range(MAX_DIMS + 1, 7);
		eff = (nd == 0) ? 1 : (nd > MAX_DIMS) ? MAX_DIMS : nd;
		for (int d = 0; d < MAX_DIMS; d++) begin
			r = $urandom_range(0, 99);
			if (d >= eff)
				lens[d] = $urandom_range(0, 8191);
			else if (r < 88)
				lens[d] = $urandom_range(1, (eff > 2) ? 3 : 6);
			else if (r < 91)
				lens[d] = 0;
			else if (r < 94)
				lens[d] = MAX_ELEMS;
			else if (r < 97)
				lens[d] = 8191;
			else
				lens[d] = $urandom_range(1, 8191);
		end
		foreach (order[i]) order[i] = i;
		r = $urandom_range(0, 99);
		if (r >= 20) begin
			for (int j = eff - 1; j > 0; j--) begin
				t = $urandom_range(0, j);
				{order[j], order[t]} = {order[t], order[j]};
			end
		end
		noise = $urandom;
		perm = noise[PERM_REG_W-1:0];
		if (r < 80)
			for (int p = 0; p < eff; p++)
				perm[2*p +: PERM_W] = order[p][PERM_W-1:0];
		mask = ALL_REGS;
		if ($urandom_range(0, 3) == 0)
			mask = noise[15:8];
		if (mask == '0)
			mask = ALL_REGS;
		set_geometry(nd, lens[0], lens[1], lens[2], lens[3], perm, mask);
	endtask

	task automatic run_random_phase();
		longint size;
		int n_load;
		int n_read;
		int mid;
		int r;
		bit small_ok;
		if ($urandom_range(0, 2) != 0)
			plan_random_config();
		else if ($urandom_range(0, 9) == 0)
			pause_until_drained();
		tx_gappy = $urandom_range(0, 3) != 0;
		rx_gappy = $urandom_range(0, 3) != 0;
		size = chk.planned_size();
		small_ok = size >= 1 && size <= SMALL_ARRAY;
		r = $urandom_range(0, 99);
		if (small_ok && r < 80)
			n_load = size;
		else if (small_ok && r < 90)
			n_load = (size > 2) ? size + $urandom_range(0, 4) - 2 : size + 1;
		else
			n_load = $urandom_range(1, 12);
		mid = (n_load > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, n_load - 1) : -1;
		load_run(n_load, mid);
		r = $urandom_range(0, 99);
		if (!small_ok || r >= 85)
			n_read = $urandom_range(0, 4);
		else if (r < 70)
			n_read = size;
		else
			n_read = size + $urandom_range(1, size);
		read_run(n_read);
		random_beats += n_load + n_read + ((mid >= 0) ? 1 : 0);
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_LOAD;
		s_tlast   <= 1'b0;
		m_tready  <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_NUM_DIMS;
		cfg_data  <= '0;
		stall_left = 0;
		random_beats = 0;
		big_done = 0;
		tx_gappy = 1;
		rx_gappy = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// nothing loaded yet, then the reset geometry: one element, identity order
		send_beat(OP_READ, '1, 1'b1);
		send_beat(OP_LOAD, '1, 1'b1);
		send_beat(OP_READ, '0, 1'b0);

		// 2x3 with axes swapped, extreme element values, one read past the end
		set_geometry(2, 2, 3, 1, 1, 8'h01, ALL_REGS);
		send_beat(OP_LOAD, '0, 1'b0);
		send_beat(OP_LOAD, '1, 1'b0);
		send_beat(OP_LOAD, {32{2'b10}}, 1'b0);
		send_beat(OP_LOAD, {32{2'b01}}, 1'b0);
		send_beat(OP_LOAD, rand_word(), 1'b0);
		send_beat(OP_LOAD, rand_word(), 1'b1);
		read_run(7);

		// repeated axis in the order
		set_geometry(2, 2, 3, 1, 1, 8'h05, 8'(1 << REG_PERM));
		load_run(1, -1);
		read_run(1);

		// huge fast stride drops the second write; read while loading
		set_geometry(2, 8191, 2, 1, 1, 8'h01, ALL_REGS);
		load_run(2, 1);
		read_run(1);

		// dimension count above range with a zero length
		set_geometry(7, 1, 1, 1, 0, PERM_RESET, ALL_REGS);
		load_run(1, -1);

		// dimension count zero, axis field out of range, spare indexes written
		set_geometry(0, MAX_ELEMS, 1, 1, 1, 8'h01,
			8'(ALL_REGS | (1 << REG_SPARE_A) | (1 << REG_SPARE_B)));
		load_run(1, -1);

		while (random_beats < RANDOM_BEATS) begin
			if (!big_done && random_beats >= RANDOM_BEATS / 2) begin
				// 4x4x4 cube, three axes rotated: one overlong load, then a clean one
				set_geometry(3, 4, 4, 4, $urandom_range(0, 8191), 8'h12, ALL_REGS);
				load_run(CUBE_SIZE + 4, -1);
				read_run(1);
				load_run(CUBE_SIZE, -1);
				read_run(CUBE_SIZE + 1);
				big_done = 1;
			end
			run_random_phase();
		end

		pause_until_drained();
		$display("beats in %0d, result beats %0d; %0d random beats plus a rotated cube run",
			chk.beats_in, chk.beats_out, random_beats);
		$display("loads closed: ok %0d, identity %0d, size mismatch %0d, bad order %0d",
			chk.load_hist[ST_OK], chk.load_hist[ST_IDENTITY], chk.load_hist[ST_MISMATCH],
			chk.load_hist[ST_INVALID]);
		if (chk.errors == 0 && chk.pending.size() == 0)
			$display("tensor_dimension_permute_core_tb: PASS");
		else
			$display("tensor_dimension_permute_core_tb: FAIL");
		$finish;
	end

endmodule
